// ===== src/sbsu_pkg.sv =====
// Shared types and constants for the sprite blitter with save-under.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package sbsu_pkg;

    // Geometry of the frame store and the save store
    localparam int HALF_WIDTH   = 512;
    localparam int FRAME_HEIGHT = 256;
    localparam int TILE_SPLIT   = 64;
    localparam int SAVE_DEPTH   = 256;

    localparam int ROW_BYTES    = 2 * HALF_WIDTH;
    localparam int FRAME_BYTES  = ROW_BYTES * FRAME_HEIGHT;
    localparam int FA_W         = $clog2(FRAME_BYTES);
    localparam int SA_W         = $clog2(SAVE_DEPTH);
    localparam int RW           = $clog2(FRAME_HEIGHT);
    localparam int CLW          = $clog2(ROW_BYTES);

    // Column math width: tile column up to 1023 plus the largest half width
    localparam int XW           = 14;

    localparam int SHIELD_LIMIT = 224;
    localparam int LEVEL_SHIFT  = 5;
    localparam int TILE_SIZE    = 8;

    // Command queue between front and back
    localparam int Q_DEPTH      = 4;
    localparam int QA_W         = $clog2(Q_DEPTH);

    typedef enum logic [2:0] {
        OP_TILE    = 3'd0,
        OP_DRAW    = 3'd1,
        OP_RESTORE = 3'd2,
        OP_COLLIDE = 3'd3,
        OP_READ    = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        CFG_ORIGIN_X = 3'd0,
        CFG_ORIGIN_Y = 3'd1,
        CFG_WIDTH    = 3'd2,
        CFG_HEIGHT   = 3'd3,
        CFG_SHIELD   = 3'd4
    } t_cfg_idx;

    typedef enum logic {
        KIND_READ    = 1'b0,
        KIND_CRASH   = 1'b1
    } t_kind;

    typedef struct packed {
        logic [9:0] origin_x;
        logic [7:0] origin_y;
        logic [7:0] width;
        logic [7:0] height;
        logic       shield;
    } t_cfg;

    // Decoded request. a_ok/fa: primary frame access (or fold enable for a
    // collision pixel); b_ok/fb: mirror write of a tile pixel.
    typedef struct packed {
        t_op             op;
        logic            a_ok;
        logic [FA_W-1:0] fa;
        logic            b_ok;
        logic [FA_W-1:0] fb;
        logic [SA_W-1:0] sidx;
        logic [7:0]      pixel;
        logic            last;
    } t_cmd;

endpackage

// ===== src/sbsu_queue.sv =====
// Short FIFO of decoded requests between front and back.
// Depends on sbsu_pkg (t_cmd, Q_DEPTH).
`timescale 1ns / 1ps

module sbsu_queue import sbsu_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_head,
    output logic o_empty
);

    t_cmd            r_mem [Q_DEPTH];
    logic [QA_W-1:0] r_wr_ptr;
    logic [QA_W-1:0] r_rd_ptr;
    logic [QA_W:0]   r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == (QA_W+1)'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (do_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr_ptr] <= i_data;
    end

endmodule

// ===== src/sbsu_front.sv =====
// Front end: accepts requests, resolves tile/sprite/read addresses and range
// checks, drops requests with no effect. Depends on sbsu_pkg.
`timescale 1ns / 1ps

module sbsu_front import sbsu_pkg::*; (
    input  t_cfg        i_cfg,
    input  logic        i_push,
    input  logic [2:0]  i_op,
    input  logic [6:0]  i_tile_col,
    input  logic [4:0]  i_tile_row,
    input  logic [2:0]  i_in_tile_x,
    input  logic [2:0]  i_in_tile_y,
    input  logic [7:0]  i_sprite_col,
    input  logic [7:0]  i_sprite_row,
    input  logic [7:0]  i_pixel,
    input  logic [9:0]  i_read_x,
    input  logic [7:0]  i_read_y,
    input  logic        i_last_pixel,
    input  logic        i_q_full,
    output logic        o_q_push,
    output t_cmd        o_q_cmd
);

    // tile pixel
    logic [XW-1:0]   tile_x;
    logic [XW-1:0]   tile_x_other;
    logic            tile_right;
    logic [7:0]      tile_y;
    logic            tile_y_ok;
    logic            tile_a_ok;
    logic            tile_b_ok;

    // sprite pixel
    logic [16:0]     save_idx;
    logic [XW-1:0]   spr_x;
    logic [8:0]      spr_y_sum;
    logic [RW-1:0]   spr_y;
    logic            spr_ok;

    // read
    logic            rd_ok;

    logic            useful;

    function automatic logic [FA_W-1:0] frame_addr(input logic [RW:0] row,
                                                   input logic [XW-1:0] col);
        frame_addr = FA_W'(row) * FA_W'(ROW_BYTES) + FA_W'(col);
    endfunction

    always_comb begin
        tile_x     = XW'(i_tile_col) * XW'(TILE_SIZE) + XW'(i_in_tile_x);
        tile_y     = {i_tile_row, 3'b000} + {5'b0, i_in_tile_y};
        tile_y_ok  = (11'(tile_y) < 11'(FRAME_HEIGHT));
        tile_right = ({2'b00, i_tile_col} >= 9'(TILE_SPLIT));
        if (tile_right) begin
            tile_x_other = tile_x - XW'(HALF_WIDTH);
            tile_b_ok    = tile_y_ok && (tile_x >= XW'(HALF_WIDTH));
        end else begin
            tile_x_other = tile_x + XW'(HALF_WIDTH);
            tile_b_ok    = tile_y_ok && (tile_x_other < XW'(ROW_BYTES));
        end
        tile_a_ok = tile_y_ok && (tile_x < XW'(ROW_BYTES));

        save_idx  = 17'(i_sprite_row) * 17'(i_cfg.width) + 17'(i_sprite_col);
        spr_x     = XW'(i_cfg.origin_x) + XW'(i_sprite_col);
        spr_y_sum = 9'(i_cfg.origin_y) + 9'(i_sprite_row);
        spr_y     = RW'(spr_y_sum % FRAME_HEIGHT);
        spr_ok    = (i_sprite_col < i_cfg.width) && (i_sprite_row < i_cfg.height)
                 && (save_idx < 17'(SAVE_DEPTH)) && (spr_x < XW'(ROW_BYTES));

        rd_ok     = (XW'(i_read_x) < XW'(ROW_BYTES))
                 && (11'(i_read_y) < 11'(FRAME_HEIGHT));

        o_q_cmd.op    = t_op'(i_op);
        o_q_cmd.a_ok  = 1'b0;
        o_q_cmd.fa    = '0;
        o_q_cmd.b_ok  = 1'b0;
        o_q_cmd.fb    = frame_addr((RW+1)'(tile_y), tile_x_other);
        o_q_cmd.sidx  = SA_W'(save_idx);
        o_q_cmd.pixel = i_pixel;
        o_q_cmd.last  = i_last_pixel;
        useful        = 1'b0;

        case (t_op'(i_op))
            OP_TILE: begin
                o_q_cmd.a_ok = tile_a_ok;
                o_q_cmd.b_ok = tile_b_ok;
                o_q_cmd.fa   = frame_addr((RW+1)'(tile_y), tile_x);
                useful       = tile_a_ok || tile_b_ok;
            end
            OP_DRAW, OP_RESTORE: begin
                o_q_cmd.a_ok = spr_ok;
                o_q_cmd.fa   = frame_addr((RW+1)'(spr_y), spr_x);
                useful       = spr_ok;
            end
            OP_COLLIDE: begin
                // transparent pixels never fold
                o_q_cmd.a_ok = spr_ok && (i_pixel != 8'd0);
                useful       = o_q_cmd.a_ok || i_last_pixel;
            end
            OP_READ: begin
                o_q_cmd.a_ok = rd_ok;
                o_q_cmd.fa   = frame_addr((RW+1)'(i_read_y), XW'(i_read_x));
                useful       = 1'b1;
            end
            default: useful = 1'b0;
        endcase

        o_q_push = i_push && !i_q_full && useful;
    end

endmodule

// ===== src/sbsu_back.sv =====
// Back end: executes decoded requests against the frame store and save
// store, keeps the collision maximum and the result register. Depends on sbsu_pkg.
`timescale 1ns / 1ps

module sbsu_back import sbsu_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_shield,
    input  t_cmd       i_head,
    input  logic       i_q_empty,
    output logic       o_q_pop,
    output logic       o_empty,
    input  logic       i_pop,
    output logic       o_result_kind,
    output logic [7:0] o_read_data,
    output logic [2:0] o_crash_level
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_TILE2
    } t_state;

    t_state          r_state;
    t_cmd            r_cmd;
    logic [7:0]      r_max;
    logic            r_out_valid;
    logic            r_out_kind;
    logic [7:0]      r_out_data;
    logic [2:0]      r_out_level;

    logic [7:0]      r_frame [FRAME_BYTES];
    logic [7:0]      r_save  [SAVE_DEPTH];
    logic [7:0]      r_frame_rd;
    logic [7:0]      r_save_rd;

    logic            frame_re;
    logic            save_re;
    logic            frame_we;
    logic [FA_W-1:0] frame_wa;
    logic [7:0]      frame_wd;
    logic            save_we;
    logic            out_free;
    logic            out_load;
    logic [7:0]      new_max;

    assign out_free = !r_out_valid || i_pop;
    assign o_q_pop  = (r_state == S_IDLE) && !i_q_empty;

    always_comb begin
        // reads are issued from the queue head as it is taken
        frame_re = o_q_pop && i_head.a_ok
                && (i_head.op == OP_DRAW || i_head.op == OP_READ);
        save_re  = o_q_pop && (i_head.op == OP_RESTORE || i_head.op == OP_COLLIDE);

        // a result is loaded this cycle
        out_load = (r_state == S_EXEC) && out_free
                && ((r_cmd.op == OP_READ) || (r_cmd.op == OP_COLLIDE && r_cmd.last));

        frame_we = 1'b0;
        frame_wa = r_cmd.fa;
        frame_wd = r_cmd.pixel;
        save_we  = 1'b0;
        case (r_state)
            S_EXEC: begin
                case (r_cmd.op)
                    OP_TILE:    frame_we = r_cmd.a_ok;
                    OP_DRAW: begin
                        save_we  = r_cmd.a_ok;
                        frame_we = r_cmd.a_ok && (r_cmd.pixel != 8'd0);
                    end
                    OP_RESTORE: begin
                        frame_we = r_cmd.a_ok;
                        frame_wd = r_save_rd;
                    end
                    default:    frame_we = 1'b0;
                endcase
            end
            S_TILE2: begin
                frame_we = r_cmd.b_ok;
                frame_wa = r_cmd.fb;
            end
            default: frame_we = 1'b0;
        endcase

        new_max = r_max;
        if (r_cmd.a_ok && (r_save_rd > r_max)
            && (!i_shield || (r_save_rd < 8'(SHIELD_LIMIT)))) begin
            new_max = r_save_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (frame_we) r_frame[frame_wa] <= frame_wd;
        if (frame_re) r_frame_rd <= r_frame[i_head.fa];
    end

    always_ff @(posedge i_clk) begin
        if (save_we) r_save[r_cmd.sidx] <= r_frame_rd;
        if (save_re) r_save_rd <= r_save[i_head.sidx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cmd       <= '0;
            r_max       <= '0;
            r_out_valid <= 1'b0;
            r_out_kind  <= 1'b0;
            r_out_data  <= '0;
            r_out_level <= '0;
        end else begin
            if (out_load) r_out_valid <= 1'b1;
            else if (i_pop && r_out_valid) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_cmd   <= i_head;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    case (r_cmd.op)
                        OP_TILE: r_state <= S_TILE2;
                        OP_COLLIDE: begin
                            if (!r_cmd.last) begin
                                r_max   <= new_max;
                                r_state <= S_IDLE;
                            end else if (out_free) begin
                                r_out_kind  <= KIND_CRASH;
                                r_out_data  <= '0;
                                r_out_level <= 3'(new_max >> LEVEL_SHIFT);
                                r_max       <= '0;
                                r_state     <= S_IDLE;
                            end
                        end
                        OP_READ: begin
                            if (out_free) begin
                                r_out_kind  <= KIND_READ;
                                r_out_data  <= r_cmd.a_ok ? r_frame_rd : 8'd0;
                                r_out_level <= '0;
                                r_state     <= S_IDLE;
                            end
                        end
                        default: r_state <= S_IDLE;
                    endcase
                end
                S_TILE2: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_empty       = !r_out_valid;
    assign o_result_kind = r_out_kind;
    assign o_read_data   = r_out_data;
    assign o_crash_level = r_out_level;

endmodule

// ===== src/sprite_blitter_with_save_under_unit.sv =====
// Top level of the sprite blitter with save-under: configuration registers,
// front end, request queue and back end. Depends on sbsu_pkg and all sbsu_* modules.
`timescale 1ns / 1ps

// Byte-per-pixel blitter over a frame store of FRAME_HEIGHT rows of
// 2*HALF_WIDTH bytes plus a SAVE_DEPTH-byte save-under store. Requests go in
// through push/full; results (reads and collision levels) come out through
// empty/pop, the oldest first. The front end resolves addresses and range
// checks in the cycle a request is taken and drops requests that do nothing
// (unused ops, fully clipped pixels); the rest go into a 4-entry queue. The
// back end, which owns the single-ported stores, takes each request through
// a read issue and then a write or result, and a tile write through a further
// state because its two mirror writes share the frame store's one write port;
// a result that finds the result register still occupied holds the back end
// until pop. The back end takes no new request until the last one is done,
// so its read-then-write sequence on the store ports sets the request rate. The config port is
// always ready; registers should be written only while the block is idle.
// Indexes beyond the register list are ignored.

module sprite_blitter_with_save_under_unit import sbsu_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,

    // configuration write channel
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [2:0] i_cfg_index,
    input  logic [9:0] i_cfg_data,

    // request side
    input  logic       push,
    output logic       full,
    input  logic [2:0] i_op,
    input  logic [6:0] i_tile_col,
    input  logic [4:0] i_tile_row,
    input  logic [2:0] i_in_tile_x,
    input  logic [2:0] i_in_tile_y,
    input  logic [7:0] i_sprite_col,
    input  logic [7:0] i_sprite_row,
    input  logic [7:0] i_pixel,
    input  logic [9:0] i_read_x,
    input  logic [7:0] i_read_y,
    input  logic       i_last_pixel,

    // result side
    output logic       empty,
    input  logic       pop,
    output logic       o_result_kind,
    output logic [7:0] o_read_data,
    output logic [2:0] o_crash_level
);

    t_cfg r_cfg;

    logic q_push;
    t_cmd q_in;
    logic q_full;
    logic q_pop;
    t_cmd q_head;
    logic q_empty;

    assign o_cfg_ready = 1'b1;
    assign full        = q_full;

    // Register file; reset values give a 16x16 sprite at the origin.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_x <= 10'd0;
            r_cfg.origin_y <= 8'd0;
            r_cfg.width    <= 8'd16;
            r_cfg.height   <= 8'd16;
            r_cfg.shield   <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_ORIGIN_X: r_cfg.origin_x <= i_cfg_data;
                CFG_ORIGIN_Y: r_cfg.origin_y <= i_cfg_data[7:0];
                CFG_WIDTH:    r_cfg.width    <= i_cfg_data[7:0];
                CFG_HEIGHT:   r_cfg.height   <= i_cfg_data[7:0];
                CFG_SHIELD:   r_cfg.shield   <= i_cfg_data[0];
                default:      r_cfg          <= r_cfg;
            endcase
        end
    end

    // Address resolution and clipping
    sbsu_front u_front (
        .i_cfg        (r_cfg),
        .i_push       (push),
        .i_op         (i_op),
        .i_tile_col   (i_tile_col),
        .i_tile_row   (i_tile_row),
        .i_in_tile_x  (i_in_tile_x),
        .i_in_tile_y  (i_in_tile_y),
        .i_sprite_col (i_sprite_col),
        .i_sprite_row (i_sprite_row),
        .i_pixel      (i_pixel),
        .i_read_x     (i_read_x),
        .i_read_y     (i_read_y),
        .i_last_pixel (i_last_pixel),
        .i_q_full     (q_full),
        .o_q_push     (q_push),
        .o_q_cmd      (q_in)
    );

    // Decouples request intake from store access
    sbsu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_empty (q_empty)
    );

    // Store access, collision fold and result register
    sbsu_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_shield      (r_cfg.shield),
        .i_head        (q_head),
        .i_q_empty     (q_empty),
        .o_q_pop       (q_pop),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_result_kind (o_result_kind),
        .o_read_data   (o_read_data),
        .o_crash_level (o_crash_level)
    );

endmodule
